>>> hdl/gbc_pkg.sv
// ----------------------------------------------------------------------------
// gbc_pkg
// Shared constants, types and helpers for the clipped 8x8 glyph blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package gbc_pkg;

  // Screen geometry (range 8..2048 each)
  localparam int SCREEN_W = 320;
  localparam int SCREEN_H = 200;

  localparam int GLYPH_DIM  = 8;
  localparam int GLYPH_BITS = GLYPH_DIM * GLYPH_DIM;
  localparam int IDX_W      = $clog2(GLYPH_BITS);
  localparam int DIM_W      = $clog2(GLYPH_DIM);

  localparam int COORD_W = 12;
  localparam int POS_W   = COORD_W + 1;
  localparam int ADDR_W  = 16;
  localparam int COLOR_W = 8;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 24;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified glyph: visible pixels, address of pixel (0,0) and ink color
  typedef struct packed {
    logic [GLYPH_BITS-1:0] mask;
    logic [ADDR_W-1:0]     base;
    logic [COLOR_W-1:0]    color;
  } glyph_rec_t;

  // Address offset of glyph row r, modulo the address width
  function automatic logic [ADDR_W-1:0] row_offset(input logic [DIM_W-1:0] r);
    int prod;
    prod = int'(r) * SCREEN_W;
    return prod[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hdl/gbc_front.sv
// ----------------------------------------------------------------------------
// gbc_front
// Accepts glyph items, clips them against the screen and pushes records
// with at least one visible pixel into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module gbc_front (
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // origin_x[11:0], origin_y[23:12], glyph_bits[87:24], ink_color[95:88]
  input  wire logic [gbc_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  input  wire logic                          q_full_i,
  output logic                               push_o,
  output gbc_pkg::glyph_rec_t                push_rec_o
);

  logic signed [gbc_pkg::COORD_W-1:0] origin_x;
  logic signed [gbc_pkg::COORD_W-1:0] origin_y;
  logic [gbc_pkg::GLYPH_BITS-1:0]     glyph_bits;
  logic [gbc_pkg::COLOR_W-1:0]        ink_color;
  logic [gbc_pkg::GLYPH_DIM-1:0]      col_ok;
  logic [gbc_pkg::GLYPH_DIM-1:0]      row_ok;
  logic signed [31:0]                 base_wide;

  assign origin_x   = s_axis_tdata_i[11:0];
  assign origin_y   = s_axis_tdata_i[23:12];
  assign glyph_bits = s_axis_tdata_i[87:24];
  assign ink_color  = s_axis_tdata_i[95:88];

  // per-column and per-row screen test
  always_comb begin
    logic signed [gbc_pkg::POS_W-1:0] px;
    logic signed [gbc_pkg::POS_W-1:0] py;
    for (int i = 0; i < gbc_pkg::GLYPH_DIM; i++) begin
      px = gbc_pkg::POS_W'(origin_x) + gbc_pkg::POS_W'(i);
      py = gbc_pkg::POS_W'(origin_y) + gbc_pkg::POS_W'(i);
      col_ok[i] = (px >= 0) && (px < gbc_pkg::POS_W'(gbc_pkg::SCREEN_W));
      row_ok[i] = (py >= 0) && (py < gbc_pkg::POS_W'(gbc_pkg::SCREEN_H));
    end
  end

  // address of glyph pixel (0,0); only the low bits matter, visible
  // pixels land right after wrapping
  assign base_wide = 32'(origin_y) * 32'(gbc_pkg::SCREEN_W) + 32'(origin_x);

  always_comb begin
    for (int r = 0; r < gbc_pkg::GLYPH_DIM; r++) begin
      for (int c = 0; c < gbc_pkg::GLYPH_DIM; c++) begin
        push_rec_o.mask[r*gbc_pkg::GLYPH_DIM + c] =
          glyph_bits[r*gbc_pkg::GLYPH_DIM + c] & row_ok[r] & col_ok[c];
      end
    end
    push_rec_o.base  = base_wide[gbc_pkg::ADDR_W-1:0];
    push_rec_o.color = ink_color;
  end

  assign s_axis_tready_o = !q_full_i;
  // fully clipped or blank glyphs are dropped here
  assign push_o = s_axis_tvalid_i && !q_full_i && (push_rec_o.mask != '0);

endmodule

`default_nettype wire

>>> hdl/gbc_queue.sv
// ----------------------------------------------------------------------------
// gbc_queue
// Short FIFO of classified glyph records between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module gbc_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  gbc_pkg::glyph_rec_t      push_rec_i,
  output logic                     full_o,
  input  wire logic                pop_i,
  output logic                     valid_o,
  output gbc_pkg::glyph_rec_t      pop_rec_o
);

  gbc_pkg::glyph_rec_t               entry_q [gbc_pkg::QUEUE_DEPTH];
  logic [gbc_pkg::QPTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [gbc_pkg::QPTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [gbc_pkg::QCNT_W-1:0]        count_q, count_d;

  function automatic logic [gbc_pkg::QPTR_W-1:0] ptr_inc(
    input logic [gbc_pkg::QPTR_W-1:0] p);
    if (p == gbc_pkg::QPTR_W'(gbc_pkg::QUEUE_DEPTH - 1)) return '0;
    return p + gbc_pkg::QPTR_W'(1);
  endfunction

  assign full_o    = (count_q == gbc_pkg::QCNT_W'(gbc_pkg::QUEUE_DEPTH));
  assign valid_o   = (count_q != '0);
  assign pop_rec_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + gbc_pkg::QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - gbc_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_rec_i;
    end
  end

endmodule

`default_nettype wire

>>> hdl/gbc_back.sv
// ----------------------------------------------------------------------------
// gbc_back
// Walks the visible-pixel mask of one glyph, lowest bit first, and emits one
// pixel write per cycle, unless back-pressured, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gbc_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           q_valid_i,
  input  gbc_pkg::glyph_rec_t                 q_rec_i,
  output logic                                pop_o,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // pixel_address[15:0], pixel_color[23:16]
  output logic [gbc_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  output logic                                m_axis_tlast_o
);

  logic [gbc_pkg::GLYPH_BITS-1:0] mask_q, mask_d;
  logic [gbc_pkg::ADDR_W-1:0]     base_q;
  logic [gbc_pkg::COLOR_W-1:0]    color_q;
  logic                           out_valid_q, out_valid_d;
  logic [gbc_pkg::ADDR_W-1:0]     out_addr_q;
  logic [gbc_pkg::COLOR_W-1:0]    out_color_q;
  logic                           out_last_q;

  logic [gbc_pkg::GLYPH_BITS-1:0] low_bit;
  logic [gbc_pkg::GLYPH_BITS-1:0] rest;
  logic [gbc_pkg::IDX_W-1:0]      idx;
  logic [gbc_pkg::ADDR_W-1:0]     pix_addr;
  logic                           advance;
  logic                           load;

  assign low_bit = mask_q & (~mask_q + gbc_pkg::GLYPH_BITS'(1));
  assign rest    = mask_q & ~low_bit;

  always_comb begin
    idx = '0;
    for (int i = 0; i < gbc_pkg::GLYPH_BITS; i++) begin
      if (low_bit[i]) idx = idx | gbc_pkg::IDX_W'(i);
    end
  end

  assign pix_addr = base_q
                  + gbc_pkg::row_offset(idx[gbc_pkg::IDX_W-1:gbc_pkg::DIM_W])
                  + gbc_pkg::ADDR_W'(idx[gbc_pkg::DIM_W-1:0]);

  assign advance = (mask_q != '0) && (!out_valid_q || m_axis_tready_i);
  // next glyph enters as soon as the current one has no pixel left
  assign load    = q_valid_i && ((mask_q == '0) || (advance && (rest == '0)));
  assign pop_o   = load;

  always_comb begin
    mask_d = mask_q;
    if (load) begin
      mask_d = q_rec_i.mask;
    end else if (advance) begin
      mask_d = rest;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      base_q  <= q_rec_i.base;
      color_q <= q_rec_i.color;
    end
    if (advance) begin
      out_addr_q  <= pix_addr;
      out_color_q <= color_q;
      out_last_q  <= (rest == '0);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_color_q, out_addr_q};
  assign m_axis_tlast_o  = out_last_q;

  // front drops empty glyphs, so a loaded record always has a pixel
  a_load_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (q_rec_i.mask != '0))
    else $error("empty glyph record reached the back end");

  a_low_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> $onehot(low_bit))
    else $error("pixel select is not one-hot");

  a_one_pixel_per_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !load) |=> ($countones(mask_q) == $countones($past(mask_q)) - 1))
    else $error("mask did not lose exactly one pixel");

endmodule

`default_nettype wire

>>> hdl/glyph_blit_clipped.sv
// ----------------------------------------------------------------------------
// glyph_blit_clipped
// Expands clipped 8x8 monochrome glyphs into linear framebuffer pixel writes.
// ----------------------------------------------------------------------------
// Each input item is one glyph (signed origin, 64 bitmap bits, ink color).
// Bit 8r+c is row r, column c, column 0 leftmost. Every set bit whose pixel
// lands on the SCREEN_W x SCREEN_H screen gives one output item with address
// py*SCREEN_W+px (mod 2^16) and the ink color, in row-then-column order;
// tlast marks the final write of a glyph. A glyph with nothing visible gives
// no output at all. Throughput: one output item per cycle while the output
// is not back-pressured, set by the back end's mask walk that retires one
// pixel per cycle; a glyph gives one write per visible set pixel (1..64) and a
// fully clipped glyph is still taken on input. The front end clips on input
// and a two-record queue sits between front and back, so new glyphs are taken
// while the previous one is still drawn; consecutive glyphs follow with no gap.
`default_nettype none

module glyph_blit_clipped (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // origin_x[11:0], origin_y[23:12], glyph_bits[87:24], ink_color[95:88]
  input  wire logic [gbc_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // pixel_address[15:0], pixel_color[23:16]
  output logic [gbc_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  // last_write
  output logic                                m_axis_tlast_o
);

  logic                q_full;
  logic                push;
  gbc_pkg::glyph_rec_t push_rec;
  logic                pop;
  logic                q_valid;
  gbc_pkg::glyph_rec_t pop_rec;

  // Front: clip each glyph into a visible-pixel mask and base address
  gbc_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .push_rec_o      (push_rec)
  );

  // Decoupling queue
  gbc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_rec_o  (pop_rec)
  );

  // Back: one pixel write per cycle while the output is not back-pressured
  gbc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_rec_i         (pop_rec),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire
